/* hdl/mma_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the multichannel moving average block.
package mma_pkg;

  localparam int LEVEL_W  = 12;
  localparam int SCALED_W = 16;
  localparam int ACTION_W = 2;
  localparam int CHAN_W   = 2;

  localparam int CHANNELS_DEF = 3;
  localparam int WINDOW_DEF   = 8;

  localparam logic [LEVEL_W-1:0] RESET_LEVEL = 12'd2048;
  localparam logic [LEVEL_W-1:0] DEAD_LOW    = 12'd20;
  localparam logic [LEVEL_W-1:0] DEAD_HIGH   = 12'd4070;
  localparam int                 FULL_SCALE  = 4095;

  // |max_out| reaches 32768, still 16 bits unsigned
  localparam int MAG_W   = 16;
  localparam int MPROD_W = LEVEL_W + MAG_W;

  // x / 4095 as (x * ceil(2^40 / 4095)) >> 40, exact for x < 2^28
  localparam int FS_SHIFT   = 40;
  localparam int FS_RECIP_W = 29;
  localparam logic [FS_RECIP_W-1:0] FS_RECIP =
    FS_RECIP_W'(((64'd1 << FS_SHIFT) + 64'(FULL_SCALE - 1)) / 64'(FULL_SCALE));

  typedef enum logic [ACTION_W-1:0] {
    ACT_FILTERED = 2'd0,
    ACT_RAW      = 2'd1,
    ACT_SCALED   = 2'd2
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic [CHAN_W-1:0]          channel;
    logic [LEVEL_W-1:0]         sample;
    logic signed [SCALED_W-1:0] max_out;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]         level;
    logic signed [SCALED_W-1:0] scaled;
    logic                       channel_ok;
  } rsp_t;

  // level handed from the filter stages to the scaling stages
  typedef struct packed {
    logic                       ok;
    logic                       scale;
    logic [LEVEL_W-1:0]         level;
    logic signed [SCALED_W-1:0] max_out;
  } lvl_t;

endpackage

/* hdl/mma_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module mma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/mma_filter.sv */
`timescale 1ns / 1ps
// Ring storage, running sums and window average stages.
module mma_filter #(
  parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
  parameter int WINDOW   = mma_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  mma_pkg::req_t             req,
  input  logic [mma_pkg::CHAN_W-1:0] scaled_channel,
  output logic                      lvl_valid,
  input  logic                      lvl_ready,
  output mma_pkg::lvl_t             lvl
);

  localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ADDR_W    = IDX_W + SLOT_W;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int SUM_W     = $clog2(mma_pkg::FULL_SCALE * WINDOW + 1);
  localparam int WIN_LOG   = $clog2(WINDOW);
  localparam int AVG_SHIFT = SUM_W + WIN_LOG;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW));
  localparam logic [SUM_W-1:0] SUM_RESET =
    SUM_W'(int'(mma_pkg::RESET_LEVEL) * WINDOW);
  localparam int LW = mma_pkg::LEVEL_W;

  // per-channel state
  logic [SLOT_W-1:0] slot   [CHANNELS];
  logic [SUM_W-1:0]  sum    [CHANNELS];
  logic [CHANNELS-1:0] filled;

  // accept-side decode
  logic [mma_pkg::CHAN_W-1:0] ch_eff;
  logic              act_ok, ok0, filt0, wrap0, hit0, accept;
  logic [IDX_W-1:0]  ch_idx0;
  logic [SLOT_W-1:0] slot0;
  logic [ADDR_W-1:0] addr0;

  // stage 1
  logic              s1_valid;
  logic              s1_ok, s1_filt, s1_scale, s1_old_valid, s1_byp;
  logic [IDX_W-1:0]  s1_ch;
  logic [ADDR_W-1:0] s1_addr;
  logic [LW-1:0]     s1_sample, s1_byp_data;
  logic signed [mma_pkg::SCALED_W-1:0] s1_max_out;
  logic [LW-1:0]     ram_rdata, old_level;
  logic [SUM_W-1:0]  sum_new;
  logic              s1_go, wr_en;

  // stage 2
  logic              s2_valid, s2_free, s1_free;
  logic              s2_ok, s2_filt, s2_scale;
  logic [LW-1:0]     s2_sample;
  logic [PROD_W-1:0] s2_prod;
  logic signed [mma_pkg::SCALED_W-1:0] s2_max_out;

  assign s2_free   = !s2_valid || lvl_ready;
  assign s1_free   = !s1_valid || s2_free;
  assign req_ready = s1_free;
  assign accept    = req_valid && s1_free;
  assign s1_go     = s1_valid && s2_free;
  assign wr_en     = s1_go && s1_filt;

  always_comb begin
    act_ok = (req.action == mma_pkg::ACT_FILTERED) || (req.action == mma_pkg::ACT_RAW) ||
             (req.action == mma_pkg::ACT_SCALED);
    ch_eff  = (req.action == mma_pkg::ACT_SCALED) ? scaled_channel : req.channel;
    ok0     = act_ok && (int'(ch_eff) < CHANNELS);
    filt0   = ok0 && (req.action != mma_pkg::ACT_RAW);
    ch_idx0 = IDX_W'(ch_eff);
    slot0   = slot[ch_idx0];
    wrap0   = (slot0 == SLOT_W'(WINDOW - 1));
    addr0   = {ch_idx0, slot0};
    hit0    = wr_en && filt0 && (s1_addr == addr0);
  end

  mma_ram #(
    .WIDTH (LW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (s1_sample),
    .re    (accept && filt0),
    .raddr (addr0),
    .rdata (ram_rdata)
  );

  // entries not yet written in the first lap read as the reset level
  always_comb begin
    if (s1_byp) begin
      old_level = s1_byp_data;
    end else if (s1_old_valid) begin
      old_level = ram_rdata;
    end else begin
      old_level = mma_pkg::RESET_LEVEL;
    end
    sum_new = sum[s1_ch] - SUM_W'(old_level) + SUM_W'(s1_sample);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      filled   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        slot[c] <= '0;
        sum[c]  <= SUM_RESET;
      end
    end else begin
      if (s1_free) begin
        s1_valid <= req_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (accept && filt0) begin
        slot[ch_idx0] <= wrap0 ? '0 : slot0 + SLOT_W'(1);
        if (wrap0) begin
          filled[ch_idx0] <= 1'b1;
        end
      end
      if (wr_en) begin
        sum[s1_ch] <= sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok        <= ok0;
      s1_filt      <= filt0;
      s1_scale     <= ok0 && (req.action == mma_pkg::ACT_SCALED);
      s1_ch        <= ch_idx0;
      s1_addr      <= addr0;
      s1_old_valid <= filled[ch_idx0];
      s1_byp       <= hit0;
      s1_byp_data  <= s1_sample;
      s1_sample    <= req.sample;
      s1_max_out   <= req.max_out;
    end
    if (s1_go) begin
      s2_ok      <= s1_ok;
      s2_filt    <= s1_filt;
      s2_scale   <= s1_scale;
      s2_sample  <= s1_sample;
      s2_max_out <= s1_max_out;
      s2_prod    <= PROD_W'(sum_new) * PROD_W'(AVG_RECIP);
    end
  end

  always_comb begin
    lvl_valid   = s2_valid;
    lvl.ok      = s2_ok;
    lvl.scale   = s2_scale;
    lvl.max_out = s2_max_out;
    if (s2_filt) begin
      lvl.level = s2_prod[AVG_SHIFT +: LW];
    end else if (s2_ok) begin
      lvl.level = s2_sample;
    end else begin
      lvl.level = '0;
    end
  end

endmodule

/* hdl/mma_scale.sv */
`timescale 1ns / 1ps
// Full-scale mapping stages with dead zones and the result register.
module mma_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          lvl_valid,
  output logic          lvl_ready,
  input  mma_pkg::lvl_t lvl,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mma_pkg::rsp_t rsp
);

  localparam int LW   = mma_pkg::LEVEL_W;
  localparam int SW   = mma_pkg::SCALED_W;
  localparam int MW   = mma_pkg::MPROD_W;
  localparam int QP_W = mma_pkg::MPROD_W + mma_pkg::FS_RECIP_W;

  logic out_free, s4_free, s3_free;
  logic neg_in;
  logic [mma_pkg::MAG_W-1:0] mag;

  logic              s3_valid, s3_ok, s3_scale, s3_neg;
  logic [LW-1:0]     s3_level;
  logic [MW-1:0]     s3_mprod;
  logic signed [SW-1:0] s3_max_out;

  logic              s4_valid, s4_ok, s4_scale, s4_neg;
  logic [LW-1:0]     s4_level;
  logic [QP_W-1:0]   s4_qprod;
  logic signed [SW-1:0] s4_max_out;

  logic [SW-1:0]        quot;
  logic signed [SW-1:0] scaled_next;

  assign out_free  = !rsp_valid || rsp_ready;
  assign s4_free   = !s4_valid || out_free;
  assign s3_free   = !s3_valid || s4_free;
  assign lvl_ready = s3_free;

  always_comb begin
    neg_in = lvl.max_out[SW-1];
    mag    = neg_in ? mma_pkg::MAG_W'(~$unsigned(lvl.max_out) + 16'd1)
                    : mma_pkg::MAG_W'($unsigned(lvl.max_out));
  end

  // magnitude quotient, sign applied afterwards: truncation toward zero
  always_comb begin
    quot = s4_qprod[mma_pkg::FS_SHIFT +: SW];
    if (!s4_scale) begin
      scaled_next = '0;
    end else if (s4_level < mma_pkg::DEAD_LOW) begin
      scaled_next = '0;
    end else if (s4_level > mma_pkg::DEAD_HIGH) begin
      scaled_next = s4_max_out;
    end else if (s4_neg) begin
      scaled_next = -$signed(quot);
    end else begin
      scaled_next = $signed(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (s3_free) begin
        s3_valid <= lvl_valid;
      end
      if (s4_free) begin
        s4_valid <= s3_valid;
      end
      if (out_free) begin
        rsp_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && lvl_valid) begin
      s3_ok      <= lvl.ok;
      s3_scale   <= lvl.scale;
      s3_neg     <= neg_in;
      s3_level   <= lvl.level;
      s3_max_out <= lvl.max_out;
      s3_mprod   <= MW'(lvl.level) * MW'(mag);
    end
    if (s4_free && s3_valid) begin
      s4_ok      <= s3_ok;
      s4_scale   <= s3_scale;
      s4_neg     <= s3_neg;
      s4_level   <= s3_level;
      s4_max_out <= s3_max_out;
      s4_qprod   <= QP_W'(s3_mprod) * QP_W'(mma_pkg::FS_RECIP);
    end
    if (out_free && s4_valid) begin
      rsp.level      <= s4_level;
      rsp.scaled     <= scaled_next;
      rsp.channel_ok <= s4_ok;
    end
  end

endmodule

/* hdl/multichannel_moving_average.sv */
`timescale 1ns / 1ps
// Top level of the multichannel boxcar moving average.
//
// Takes one item per clock while req_ready is high; one result per item
// comes back, in order, via the filter, scaling and result registers. The
// rate is set by the sample ring RAM: one read (at acceptance) and one
// write (from stage 1, with a bypass for back-to-back hits) per cycle; the
// running sums sit in registers. Per-channel fill flags make unwritten
// ring entries read as 2048; no clearing pass is needed after reset. The
// user writes scaled_channel (cfg_we/cfg_data) only while idle, unchecked.
module multichannel_moving_average #(
  parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
  parameter int WINDOW   = mma_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  mma_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output mma_pkg::rsp_t              rsp,
  input  logic                       cfg_we,
  input  logic [mma_pkg::CHAN_W-1:0] cfg_data
);

  logic [mma_pkg::CHAN_W-1:0] scaled_channel;
  logic          lvl_valid, lvl_ready;
  mma_pkg::lvl_t lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_channel <= '0;
    end else if (cfg_we) begin
      scaled_channel <= cfg_data;
    end
  end

  mma_filter #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_filter (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .scaled_channel (scaled_channel),
    .lvl_valid      (lvl_valid),
    .lvl_ready      (lvl_ready),
    .lvl            (lvl)
  );

  mma_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl       (lvl),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
